[src/osict_pkg.sv]
package osict_pkg;

	// Defaults for the top-level parameters
	localparam int CAPACITY_DEF   = 16;
	localparam int COUNT_BITS_DEF = 16;

	// Fixed field widths
	localparam int OP_W   = 2;
	localparam int KEY_W  = 32;
	localparam int SLOT_W = 4;
	localparam int DUP_W  = 16;

	// Operation codes
	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_COUNT  = 2'd2
	} op_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// One result word
	typedef struct packed {
		logic              found;
		logic              inserted;
		logic              full_refused;
		logic [SLOT_W-1:0] slot_index;
		logic [DUP_W-1:0]  dup_count;
	} res_t;

endpackage

[src/osict_req_if.sv]
interface osict_req_if;
	logic                             valid;
	logic                             ready;
	logic [osict_pkg::OP_W-1:0]       opcode;
	logic signed [osict_pkg::KEY_W-1:0] key;

	modport source (output valid, output opcode, output key, input ready);
	modport sink (input valid, input opcode, input key, output ready);
endinterface

[src/osict_rsp_if.sv]
interface osict_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         found;
	logic                         inserted;
	logic                         full_refused;
	logic [osict_pkg::SLOT_W-1:0] slot_index;
	logic [osict_pkg::DUP_W-1:0]  dup_count;

	modport source (output valid, output found, output inserted, output full_refused,
		output slot_index, output dup_count, input ready);
	modport sink (input valid, input found, input inserted, input full_refused,
		input slot_index, input dup_count, output ready);
endinterface

[src/osict_store.sv]
module osict_store #(
	parameter int DEPTH      = osict_pkg::CAPACITY_DEF,
	parameter int COUNT_BITS = osict_pkg::COUNT_BITS_DEF,
	parameter int AW         = 4
) (
	input  logic                        clk,
	input  logic                        rd_en,
	input  logic [AW-1:0]               rd_addr,
	output logic [osict_pkg::KEY_W-1:0] key_rd,
	output logic [COUNT_BITS-1:0]       cnt_rd,
	input  logic                        key_we,
	input  logic                        cnt_we,
	input  logic [AW-1:0]               wr_addr,
	input  logic [osict_pkg::KEY_W-1:0] wr_key,
	input  logic [COUNT_BITS-1:0]       wr_cnt
);

	logic [osict_pkg::KEY_W-1:0] key_mem [DEPTH];
	logic [COUNT_BITS-1:0]       cnt_mem [DEPTH];
	logic [osict_pkg::KEY_W-1:0] key_rd_q;
	logic [COUNT_BITS-1:0]       cnt_rd_q;

	// Write port, key and counter written separately
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[wr_addr] <= wr_key;
		end
		if (cnt_we) begin
			cnt_mem[wr_addr] <= wr_cnt;
		end
	end

	// Registered read port, one entry per cycle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			key_rd_q <= key_mem[rd_addr];
			cnt_rd_q <= cnt_mem[rd_addr];
		end
	end

	assign key_rd = key_rd_q;
	assign cnt_rd = cnt_rd_q;

endmodule

[src/osict_seq.sv]
module osict_seq #(
	parameter int CAPACITY   = osict_pkg::CAPACITY_DEF,
	parameter int COUNT_BITS = osict_pkg::COUNT_BITS_DEF,
	parameter int AW         = 4,
	parameter int CW         = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [osict_pkg::OP_W-1:0]  op_in,
	input  logic [osict_pkg::KEY_W-1:0] key_in,
	output logic                        idle,
	input  logic                        out_free,
	output logic                        res_valid,
	output osict_pkg::res_t             res,
	output logic                        rd_en,
	output logic [AW-1:0]               rd_addr,
	input  logic [osict_pkg::KEY_W-1:0] key_rd,
	input  logic [COUNT_BITS-1:0]       cnt_rd,
	output logic                        key_we,
	output logic                        cnt_we,
	output logic [AW-1:0]               wr_addr,
	output logic [osict_pkg::KEY_W-1:0] wr_key,
	output logic [COUNT_BITS-1:0]       wr_cnt
);

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	osict_pkg::state_t state_q, state_d;
	osict_pkg::op_t    op_q;
	logic [osict_pkg::KEY_W-1:0] key_q;
	logic [CW-1:0]     idx_q;
	logic [CW-1:0]     used_q;
	logic              pend_s1;
	logic [AW-1:0]     pidx_s1;
	osict_pkg::res_t   res_q, res_d;

	logic              scanning;
	logic              hit;
	logic              miss;
	logic              is_ins;
	logic              has_room;
	logic [COUNT_BITS-1:0] cnt_next;
	logic [31:0]       hit_slot_ext;
	logic [31:0]       new_slot_ext;
	logic [31:0]       hit_cnt_ext;

	// Compare unit: one stored key against the search key each cycle
	assign scanning = (state_q == osict_pkg::ST_SCAN);
	assign rd_en    = scanning && (idx_q < used_q);
	assign rd_addr  = idx_q[AW-1:0];
	assign hit      = scanning && pend_s1 && (key_rd == key_q);
	assign miss     = scanning && !pend_s1 && !rd_en;
	assign is_ins   = (op_q == osict_pkg::OP_INSERT);
	assign has_room = (used_q < CW'(CAPACITY));

	// Saturating counter step
	assign cnt_next = (cnt_rd == CNT_MAX) ? cnt_rd : cnt_rd + 1'b1;

	// Store updates: counter bump on a duplicate, append on a new key
	assign key_we  = miss && is_ins && has_room;
	assign cnt_we  = (hit && is_ins) || key_we;
	assign wr_addr = hit ? pidx_s1 : used_q[AW-1:0];
	assign wr_key  = key_q;
	assign wr_cnt  = hit ? cnt_next : '0;

	assign hit_slot_ext = 32'(pidx_s1);
	assign new_slot_ext = 32'(used_q);
	assign hit_cnt_ext  = is_ins ? 32'(cnt_next) : 32'(cnt_rd);

	assign idle      = (state_q == osict_pkg::ST_IDLE);
	assign res_valid = (state_q == osict_pkg::ST_DONE) && out_free;
	assign res       = res_q;

	// Next state and result
	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		case (state_q)
			osict_pkg::ST_IDLE: begin
				if (start) begin
					res_d = '0;
					case (osict_pkg::op_t'(op_in))
						osict_pkg::OP_INSERT,
						osict_pkg::OP_LOOKUP,
						osict_pkg::OP_COUNT: state_d = osict_pkg::ST_SCAN;
						default: state_d = osict_pkg::ST_DONE;
					endcase
				end
			end
			osict_pkg::ST_SCAN: begin
				if (hit) begin
					res_d.found      = 1'b1;
					res_d.slot_index = hit_slot_ext[osict_pkg::SLOT_W-1:0];
					res_d.dup_count  = hit_cnt_ext[osict_pkg::DUP_W-1:0];
					state_d = osict_pkg::ST_DONE;
				end else if (miss) begin
					if (is_ins && has_room) begin
						res_d.inserted   = 1'b1;
						res_d.slot_index = new_slot_ext[osict_pkg::SLOT_W-1:0];
					end else if (is_ins) begin
						res_d.full_refused = 1'b1;
					end
					state_d = osict_pkg::ST_DONE;
				end
			end
			osict_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = osict_pkg::ST_IDLE;
				end
			end
			default: state_d = osict_pkg::ST_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= osict_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: scan index, fill count, read pipeline flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			used_q  <= '0;
			pend_s1 <= 1'b0;
		end else begin
			if (idle && start) begin
				idx_q   <= '0;
				pend_s1 <= 1'b0;
			end else if (scanning) begin
				pend_s1 <= rd_en;
				if (rd_en) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (key_we) begin
				used_q <= used_q + 1'b1;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (idle && start) begin
			op_q  <= osict_pkg::op_t'(op_in);
			key_q <= key_in;
		end
		if (scanning) begin
			pidx_s1 <= idx_q[AW-1:0];
		end
		res_q <= res_d;
	end

endmodule

[src/ordered_set_insert_count_table_unit.sv]
// Insertion-ordered key table with a saturating duplicate counter per slot.
// Request channel (req): opcode and a 32-bit key; one word per operation.
//   insert: a stored key gets its counter bumped (saturating); a new key is
//           appended at the next free slot with a count of zero, or refused
//           with full_refused when all CAPACITY slots are in use.
//   lookup / count: report found, slot_index and dup_count of the key.
//   Opcode 3 returns an all-zero result and changes nothing.
// Response channel (rsp): exactly one word per request, in request order.
// Scan: the table is scanned one slot per cycle through the single read
//   port of the key memory until a hit or the last used slot; opcode 3
//   skips the scan. One request is in flight at a time; req.ready is high
//   only while the sequencer is idle.
// A finished result sits in an output register, so the next request is taken
//   while rsp waits; if rsp stalls, the following result holds in the
//   sequencer until the register frees.
// Reset empties the table at once (fill count to zero); no clearing pass.
module ordered_set_insert_count_table_unit #(
	parameter int CAPACITY   = osict_pkg::CAPACITY_DEF,
	parameter int COUNT_BITS = osict_pkg::COUNT_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	osict_req_if.sink   req,
	osict_rsp_if.source rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic                        seq_idle;
	logic                        start;
	logic                        out_free;
	logic                        res_valid;
	osict_pkg::res_t             res;
	logic                        rd_en;
	logic [AW-1:0]               rd_addr;
	logic [osict_pkg::KEY_W-1:0] key_rd;
	logic [COUNT_BITS-1:0]       cnt_rd;
	logic                        key_we;
	logic                        cnt_we;
	logic [AW-1:0]               wr_addr;
	logic [osict_pkg::KEY_W-1:0] wr_key;
	logic [COUNT_BITS-1:0]       wr_cnt;
	logic                        out_valid_q;
	osict_pkg::res_t             out_res_q;

	assign req.ready = seq_idle;
	assign start     = req.valid && seq_idle;

	osict_seq #(
		.CAPACITY   (CAPACITY),
		.COUNT_BITS (COUNT_BITS),
		.AW         (AW),
		.CW         (CW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.op_in     (req.opcode),
		.key_in    ($unsigned(req.key)),
		.idle      (seq_idle),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.key_rd    (key_rd),
		.cnt_rd    (cnt_rd),
		.key_we    (key_we),
		.cnt_we    (cnt_we),
		.wr_addr   (wr_addr),
		.wr_key    (wr_key),
		.wr_cnt    (wr_cnt)
	);

	osict_store #(
		.DEPTH      (CAPACITY),
		.COUNT_BITS (COUNT_BITS),
		.AW         (AW)
	) u_store (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.key_rd  (key_rd),
		.cnt_rd  (cnt_rd),
		.key_we  (key_we),
		.cnt_we  (cnt_we),
		.wr_addr (wr_addr),
		.wr_key  (wr_key),
		.wr_cnt  (wr_cnt)
	);

	// Output register between sequencer and rsp
	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_res_q <= res;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.found        = out_res_q.found;
	assign rsp.inserted     = out_res_q.inserted;
	assign rsp.full_refused = out_res_q.full_refused;
	assign rsp.slot_index   = out_res_q.slot_index;
	assign rsp.dup_count    = out_res_q.dup_count;

`ifndef NO_ASSERTIONS
	// One request at a time: ready drops right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while a scan was running");

	// A word never reports a hit together with an append or a refusal
	a_hit_xor_append: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.found && rsp.inserted) && !(rsp.found && rsp.full_refused))
		else $error("conflicting result flags");

	// Absent keys report no slot contents
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.found) |-> (rsp.dup_count == '0))
		else $error("nonzero count for an absent key");

	// A refused insert reports slot zero
	a_refused_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.full_refused) |-> (rsp.slot_index == '0))
		else $error("refused insert with a slot index");
`endif

endmodule

[tb/osict_table_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the key table, keeps its own copy of the table and
// checks every result word against the oldest outstanding prediction.
module osict_table_checker (
	input  logic        clk,
	input  logic        arst_n,
	osict_req_if        req,
	osict_rsp_if        rsp,
	output int unsigned errors,
	output int unsigned outstanding,
	output int unsigned checked,
	output int unsigned hits,
	output int unsigned appends,
	output int unsigned refusals
);

	localparam int TBL_DEPTH = osict_pkg::CAPACITY_DEF;
	localparam int CNT_W     = osict_pkg::COUNT_BITS_DEF;
	localparam int MAX_SHOWN = 40;

	// Shadow table
	logic [osict_pkg::KEY_W-1:0] key_tbl [TBL_DEPTH];
	logic [CNT_W-1:0]            cnt_tbl [TBL_DEPTH];
	int unsigned                 fill;

	// Predicted result words, oldest first
	osict_pkg::res_t due_q [$];

	// Apply one operation to the shadow table and return the word it should give
	function automatic osict_pkg::res_t apply_table_op(input logic [osict_pkg::OP_W-1:0] op,
		input logic [osict_pkg::KEY_W-1:0] k);
		osict_pkg::res_t r;
		int              hit;
		r   = '0;
		hit = -1;
		// first match in slot order; unwritten slots are never compared
		for (int i = 0; i < TBL_DEPTH; i++) begin
			if (hit < 0 && i < fill && key_tbl[i] == k) begin
				hit = i;
			end
		end
		case (op)
			osict_pkg::OP_INSERT, osict_pkg::OP_LOOKUP, osict_pkg::OP_COUNT: begin
				if (hit >= 0) begin
					r.found      = 1'b1;
					r.slot_index = osict_pkg::SLOT_W'(hit);
					// duplicate insert, counter sticks at all ones
					if (op == osict_pkg::OP_INSERT && cnt_tbl[hit] != '1) begin
						cnt_tbl[hit] = cnt_tbl[hit] + 1'b1;
					end
					r.dup_count = osict_pkg::DUP_W'(cnt_tbl[hit]);
				end else if (op == osict_pkg::OP_INSERT) begin
					if (fill < TBL_DEPTH) begin
						r.inserted    = 1'b1;
						r.slot_index  = osict_pkg::SLOT_W'(fill);
						key_tbl[fill] = k;
						cnt_tbl[fill] = '0;
						fill++;
					end else begin
						r.full_refused = 1'b1;
					end
				end
			end
			default: begin
				// spare opcode: all-zero word, table untouched
			end
		endcase
		return r;
	endfunction

	function automatic void check_field(input string what, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			errors++;
			if (errors <= MAX_SHOWN) begin
				$display("%0t: %s mismatch on word %0d, expected 0x%0h, got 0x%0h",
					$time, what, checked, want, got);
			end
		end
	endfunction

	// Compare departing words, predict arriving ones
	always @(posedge clk or negedge arst_n) begin : watch
		osict_pkg::res_t want;
		if (!arst_n) begin
			fill     = 0;
			errors   = 0;
			checked  = 0;
			hits     = 0;
			appends  = 0;
			refusals = 0;
			due_q.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (due_q.size() == 0) begin
					errors++;
					if (errors <= MAX_SHOWN) begin
						$display("%0t: unexpected word, expected none, got %b/%b/%b %0d %0d",
							$time, rsp.found, rsp.inserted, rsp.full_refused,
							rsp.slot_index, rsp.dup_count);
					end
				end else begin
					want = due_q.pop_front();
					check_field("found", 32'(want.found), 32'(rsp.found));
					check_field("inserted", 32'(want.inserted), 32'(rsp.inserted));
					check_field("full_refused", 32'(want.full_refused),
						32'(rsp.full_refused));
					check_field("slot_index", 32'(want.slot_index), 32'(rsp.slot_index));
					check_field("dup_count", 32'(want.dup_count), 32'(rsp.dup_count));
					checked++;
				end
			end
			if (req.valid && req.ready) begin
				want = apply_table_op(req.opcode, req.key);
				if (want.found) hits++;
				if (want.inserted) appends++;
				if (want.full_refused) refusals++;
				due_q.push_back(want);
			end
		end
		outstanding = due_q.size();
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

	localparam logic [osict_pkg::OP_W-1:0] OP_SPARE = 2'd3;

	localparam int RAND_WORDS = 1820;
	// short back-to-back run of duplicate inserts on one key
	localparam int DUP_WORDS  = 12;
	localparam int POOL_N     = 28;
	localparam int HOLD_AFTER = 400;
	localparam int LONG_HOLD  = 300;
	localparam int SETTLE     = 40;
	// slowest run: ~1850 words plus gaps and stalls
	localparam int unsigned LIMIT = 600000;

	logic clk;
	logic arst_n;

	osict_req_if req();
	osict_rsp_if rsp();

	int unsigned errors, outstanding, checked, hits, appends, refusals;
	int unsigned cycles;
	int unsigned sent;
	int unsigned burst_left;
	bit          rx_free;

	logic [osict_pkg::KEY_W-1:0] key_pool [POOL_N];

	ordered_set_insert_count_table_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	osict_table_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.errors      (errors),
		.outstanding (outstanding),
		.checked     (checked),
		.hits        (hits),
		.appends     (appends),
		.refusals    (refusals)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT) begin
			$display("Timeout after %0d cycles, %0d words outstanding", cycles, outstanding);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Result side: random ready pattern, one long hold-off, or always ready
	initial begin : rsp_side
		bit          rx_on;
		bit          held;
		int unsigned rx_left;
		int unsigned words;
		rx_on     = 1'b1;
		held      = 1'b0;
		rx_left   = 0;
		words     = 0;
		rsp.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready && !rx_free) words++;
			if (rx_free) begin
				rsp.ready <= 1'b1;
			end else if (!held && words >= HOLD_AFTER) begin
				// long hold: the block backs up and stops taking requests
				held = 1'b1;
				rsp.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				rsp.ready <= 1'b1;
			end else begin
				if (rx_left == 0) begin
					rx_on   = ($urandom_range(0, 3) != 0);
					rx_left = rx_on ? $urandom_range(1, ($urandom_range(0, 7) == 0) ? 60 : 10)
						: $urandom_range(1, 6);
				end
				rx_left--;
				rsp.ready <= rx_on;
			end
		end
	end

	// Offer one word and hold it until the block takes it
	task automatic put_word(input logic [osict_pkg::OP_W-1:0] op,
		input logic [osict_pkg::KEY_W-1:0] k);
		req.valid  <= 1'b1;
		req.opcode <= op;
		req.key    <= k;
		do @(posedge clk); while (req.ready !== 1'b1);
		sent++;
	endtask

	// Bursts of random length with random gaps in between
	task automatic pace();
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
			if (gap != 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	// Stop offering until every predicted word is back; returns on a falling edge
	task automatic wait_all_back();
		req.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	initial begin : stimulus
		logic [osict_pkg::OP_W-1:0]  op;
		logic [osict_pkg::KEY_W-1:0] k;
		int unsigned                 pick;
		arst_n     = 1'b0;
		req.valid  = 1'b0;
		req.opcode = osict_pkg::OP_INSERT;
		req.key    = '0;
		rx_free    = 1'b0;
		cycles     = 0;
		sent       = 0;
		burst_left = 0;

		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hFFFF_FFFF;
		key_pool[4] = 32'hAAAA_AAAA;
		key_pool[5] = 32'h5555_5555;
		for (int i = 6; i < POOL_N; i++) key_pool[i] = $urandom();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed: empty table, spare opcode, extreme keys, duplicates, misses
		pace(); put_word(osict_pkg::OP_LOOKUP, 32'h0000_0000);
		pace(); put_word(osict_pkg::OP_COUNT, 32'h7FFF_FFFF);
		pace(); put_word(OP_SPARE, 32'hFFFF_FFFF);
		for (int i = 0; i < 4; i++) begin
			pace(); put_word(osict_pkg::OP_INSERT, key_pool[i]);
		end
		pace(); put_word(osict_pkg::OP_INSERT, 32'h8000_0000);
		pace(); put_word(osict_pkg::OP_LOOKUP, 32'hFFFF_FFFF);
		pace(); put_word(osict_pkg::OP_COUNT, 32'h8000_0000);
		pace(); put_word(osict_pkg::OP_LOOKUP, 32'h7FFF_FFFE);
		pace(); put_word(osict_pkg::OP_COUNT, 32'h0000_0001);
		pace(); put_word(OP_SPARE, 32'h8000_0000);
		pace(); put_word(osict_pkg::OP_INSERT, key_pool[4]);
		pace(); put_word(osict_pkg::OP_INSERT, key_pool[5]);
		pace(); put_word(osict_pkg::OP_LOOKUP, key_pool[5]);
		wait_all_back();

		// Duplicate inserts on one key, back to back with the receiver always ready
		rx_free = 1'b1;
		@(posedge clk);
		for (int i = 0; i < DUP_WORDS; i++) put_word(osict_pkg::OP_INSERT, 32'h7FFF_FFFF);
		put_word(osict_pkg::OP_COUNT, 32'h7FFF_FFFF);
		put_word(osict_pkg::OP_LOOKUP, 32'h7FFF_FFFF);
		wait_all_back();
		rx_free = 1'b0;
		@(posedge clk);

		// Random: mostly pool keys so the table fills and hits repeat
		for (int n = 0; n < RAND_WORDS; n++) begin
			if (n == RAND_WORDS / 2) begin
				wait_all_back();
				@(posedge clk);
			end
			pick = $urandom_range(0, 99);
			if (pick < 45) op = osict_pkg::OP_INSERT;
			else if (pick < 70) op = osict_pkg::OP_LOOKUP;
			else if (pick < 95) op = osict_pkg::OP_COUNT;
			else op = OP_SPARE;
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				k = key_pool[$urandom_range(0, POOL_N - 1)];
			end else if (pick < 75) begin
				// near miss: one bit off a pool key
				k = key_pool[$urandom_range(0, POOL_N - 1)];
				k[$urandom_range(0, osict_pkg::KEY_W - 1)] ^= 1'b1;
			end else begin
				k = $urandom();
			end
			pace();
			put_word(op, k);
		end

		wait_all_back();
		repeat (SETTLE) @(posedge clk);
		$display("Sent %0d words (%0d back to back on one key), checked %0d results",
			sent, DUP_WORDS, checked);
		$display("Keys found %0d times, %0d appended, %0d inserts refused on a full table",
			hits, appends, refusals);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
